// ----- sv/tlptm_pkg.sv -----
package tlptm_pkg;

  localparam int DIR_LIMIT     = 16;
  localparam int TABLE_ENTRIES = 1024;
  localparam int FIXED_TABLES  = 4;
  localparam int SPARE_TABLES  = 12;
  localparam int TOTAL_SLOTS   = FIXED_TABLES + SPARE_TABLES;
  localparam int TOTAL_WORDS   = TOTAL_SLOTS * TABLE_ENTRIES;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DIR_W   = (DIR_LIMIT > 1) ? $clog2(DIR_LIMIT) : 1;
  localparam int SPARE_W = (SPARE_TABLES > 1) ? $clog2(SPARE_TABLES) : 1;
  localparam int INIT_W  = $clog2(FIXED_TABLES * TABLE_ENTRIES);

  localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;
  localparam logic [11:0] FLAG_PRESENT  = 12'h001;
  localparam logic [11:0] FLAG_WRITABLE = 12'h002;
  localparam logic [11:0] FLAG_USER     = 12'h004;

  typedef enum logic [2:0] {
    OP_MAP       = 3'd0,
    OP_UNMAP     = 3'd1,
    OP_QUERY     = 3'd2,
    OP_TRANSLATE = 3'd3,
    OP_GET_FLAGS = 3'd4,
    OP_SET_FLAGS = 3'd5
  } op_t;

  typedef struct packed {
    logic              present;
    logic              writable;
    logic              user;
    logic [SLOT_W-1:0] slot;
  } dir_entry_t;

endpackage

// ----- sv/two_level_page_table_manager_unit.sv -----
// two-level page table manager
// in channel: in_valid/in_ready with operation, virt_addr, phys_addr
// and page_flags; out channel: out_valid/out_ready with success,
// translated_address and entry_flags. one result beat per request beat.
// page entries live in a single-port synchronous ram of 16 slots x 1024 words;
// the directory and the slot allocation bits are flops.
// steps: query/translate/get/unmap/set flags go through accept, directory
// check + ram read, execute and the result register. a map to a present
// directory entry writes the ram in the check step; a map that allocates a
// spare slot sweeps the slot to zero first, one word a cycle, then writes
// the entry. the ram port is the limit: one access per cycle.
// a new request is taken once the previous one has reached the result
// register, so a stalled receiver holds one finished result while the
// next request is worked on; that one waits until the register frees.
// after reset the block writes the identity map of the fixed slots with
// in_ready low.
module two_level_page_table_manager_unit
  import tlptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [11:0] page_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [31:0] translated_address,
  output logic [11:0] entry_flags
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CHECK, S_CLEAR, S_MAPW, S_EXEC, S_RESP
  } state_t;

  state_t state;

  logic [31:0] mem [TOTAL_WORDS];
  logic [31:0] rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0]       mem_wd;

  dir_entry_t        directory [DIR_LIMIT];
  logic [SPARE_TABLES-1:0] slot_in_use;

  logic [2:0]  op_q;
  logic [31:0] va_q;
  logic [31:0] pa_q;
  logic [11:0] fl_q;

  logic [INIT_W-1:0] init_cnt;
  logic [IDX_W-1:0]  clr_cnt;

  logic        res_ok;
  logic [31:0] res_xlat;
  logic [11:0] res_fl;

  logic [9:0]        dir_idx;
  logic              dir_ok;
  dir_entry_t        dent;
  logic              aligned;
  logic              pre_ok;
  logic              map_go;
  logic [ADDR_W-1:0] page_ptr;
  logic [31:0]       map_word;
  logic [31:0]       set_word;
  logic              free_found;
  logic [SPARE_W-1:0] free_idx;

  assign dir_idx  = va_q[31:22];
  assign dir_ok   = 32'(dir_idx) < DIR_LIMIT;
  assign dent     = directory[dir_idx[DIR_W-1:0]];
  assign aligned  = (va_q[11:0] == 12'h000);
  assign pre_ok   = (op_q <= OP_SET_FLAGS) && dir_ok &&
                    (aligned || op_q == OP_TRANSLATE || op_q == OP_GET_FLAGS);
  assign map_go   = pre_ok && (op_q == OP_MAP) && (pa_q[11:0] == 12'h000);
  assign page_ptr = {dent.slot, va_q[21:12]};
  assign map_word = (pa_q & FRAME_MASK) | {20'h0, fl_q | FLAG_PRESENT};
  assign set_word = (rd_q & FRAME_MASK) | {20'h0, fl_q | FLAG_PRESENT};
  assign in_ready = (state == S_IDLE);

  // first free spare slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SPARE_TABLES - 1; i >= 0; i--) begin
      if (!slot_in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SPARE_W'(i);
      end
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = page_ptr;
    mem_wd   = '0;
    unique case (state)
      S_INIT: begin
        mem_we   = 1'b1;
        mem_addr = ADDR_W'(init_cnt);
        mem_wd   = (32'(init_cnt) << 12) | {20'h0, FLAG_PRESENT | FLAG_WRITABLE};
      end
      S_CHECK: begin
        if (map_go && dent.present) begin
          mem_we = 1'b1;
          mem_wd = map_word;
        end
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = {dent.slot, clr_cnt};
      end
      S_MAPW: begin
        mem_we = 1'b1;
        mem_wd = map_word;
      end
      S_EXEC: begin
        if (op_q == OP_UNMAP) begin
          mem_we = 1'b1;
        end else if (op_q == OP_SET_FLAGS && rd_q[0]) begin
          mem_we = 1'b1;
          mem_wd = set_word;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_cnt    <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      slot_in_use <= '0;
      for (int i = 0; i < DIR_LIMIT; i++) begin
        directory[i].present  <= (i < FIXED_TABLES);
        directory[i].writable <= (i < FIXED_TABLES);
        directory[i].user     <= 1'b0;
        directory[i].slot     <= (i < FIXED_TABLES) ? SLOT_W'(i) : '0;
      end
    end else begin
      // the result state loads a new beat itself
      if (out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (&init_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= operation;
            va_q  <= virt_addr;
            pa_q  <= phys_addr;
            fl_q  <= page_flags;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_xlat <= '0;
          res_fl   <= '0;
          if (map_go && !dent.present && free_found) begin
            res_ok <= 1'b0;
            slot_in_use[free_idx] <= 1'b1;
            directory[dir_idx[DIR_W-1:0]] <= '{present: 1'b1, writable: 1'b1,
              user: fl_q[2], slot: SLOT_W'(FIXED_TABLES) + SLOT_W'(free_idx)};
            clr_cnt <= '0;
            state   <= S_CLEAR;
          end else if (pre_ok && op_q != OP_MAP && dent.present) begin
            res_ok <= 1'b0;
            state  <= S_EXEC;
          end else begin
            res_ok <= map_go && dent.present;
            if (map_go && dent.present && fl_q[2]) begin
              directory[dir_idx[DIR_W-1:0]].user <= 1'b1;
            end
            state <= S_RESP;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_MAPW;
          end
        end
        S_MAPW: begin
          res_ok <= 1'b1;
          state  <= S_RESP;
        end
        S_EXEC: begin
          state <= S_RESP;
          case (op_q)
            OP_UNMAP: res_ok <= 1'b1;
            OP_QUERY: res_ok <= rd_q[0];
            OP_TRANSLATE: begin
              if (rd_q[0]) begin
                res_ok   <= 1'b1;
                res_xlat <= (rd_q & FRAME_MASK) | {20'h0, va_q[11:0]};
              end
            end
            OP_GET_FLAGS: begin
              res_ok <= 1'b1;
              res_fl <= rd_q[11:0];
            end
            OP_SET_FLAGS: begin
              if (rd_q[0]) begin
                res_ok <= 1'b1;
                if (fl_q[2]) begin
                  directory[dir_idx[DIR_W-1:0]].user <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            success            <= res_ok;
            translated_address <= res_xlat;
            entry_flags        <= res_fl;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_writes: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> mem_we)
    else $error("slot clear cycle without a ram write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_xlat_only_on_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && (translated_address != 32'h0 || entry_flags != 12'h000) |-> success)
    else $error("result data on a failed operation");

  a_slots_never_freed: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((slot_in_use & $past(slot_in_use)) == $past(slot_in_use)))
    else $error("spare slot released");
`endif

endmodule

// ----- tb/two_level_page_table_manager_unit_checker.sv -----
module two_level_page_table_manager_unit_checker
  import tlptm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [11:0] page_flags,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        success,
  input  logic [31:0] translated_address,
  input  logic [11:0] entry_flags,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic        ok;
    logic [31:0] xlat;
    logic [11:0] flags;
  } page_result_t;

  logic              dir_present [DIR_LIMIT];
  logic              dir_user    [DIR_LIMIT];
  logic [SLOT_W-1:0] dir_slot    [DIR_LIMIT];
  logic [31:0]       page_words  [TOTAL_WORDS];
  logic              spare_taken [SPARE_TABLES];
  page_result_t      result_q[$];

  task automatic reset_tables();
    for (int i = 0; i < DIR_LIMIT; i++) begin
      dir_present[i] = (i < FIXED_TABLES);
      dir_user[i]    = 1'b0;
      dir_slot[i]    = (i < FIXED_TABLES) ? SLOT_W'(i) : '0;
    end
    for (int i = 0; i < SPARE_TABLES; i++) spare_taken[i] = 1'b0;
    for (int s = 0; s < TOTAL_SLOTS; s++)
      for (int j = 0; j < TABLE_ENTRIES; j++)
        page_words[s*TABLE_ENTRIES+j] = (s < FIXED_TABLES) ?
          ((32'(s) << 22) + (32'(j) << 12)) | 32'(FLAG_PRESENT | FLAG_WRITABLE) : 32'd0;
  endtask

  function automatic page_result_t walk_tables(logic [2:0] opc, logic [31:0] va,
                                               logic [31:0] pa, logic [11:0] fl);
    page_result_t r;
    int unsigned dix;
    int pos;
    int free_slot;
    r = '{1'b0, 32'd0, 12'd0};
    dix = va[31:22];
    free_slot = -1;
    if (opc > OP_SET_FLAGS || dix >= DIR_LIMIT) return r;
    if (va[11:0] != 0 && opc != OP_TRANSLATE && opc != OP_GET_FLAGS) return r;
    if (opc == OP_MAP) begin
      if (pa[11:0] != 0) return r;
      if (!dir_present[dix]) begin
        for (int i = SPARE_TABLES - 1; i >= 0; i--)
          if (!spare_taken[i]) free_slot = i;
        if (free_slot < 0) return r;
        spare_taken[free_slot] = 1'b1;
        for (int j = 0; j < TABLE_ENTRIES; j++)
          page_words[(FIXED_TABLES+free_slot)*TABLE_ENTRIES+j] = 32'd0;
        dir_present[dix] = 1'b1;
        dir_user[dix]    = 1'b0;
        dir_slot[dix]    = SLOT_W'(FIXED_TABLES + free_slot);
      end
      if (fl[2]) dir_user[dix] = 1'b1;
      pos = dir_slot[dix] * TABLE_ENTRIES + va[21:12];
      page_words[pos] = (pa & FRAME_MASK) | 32'(fl) | 32'(FLAG_PRESENT);
      r.ok = 1'b1;
      return r;
    end
    if (!dir_present[dix]) return r;
    pos = dir_slot[dix] * TABLE_ENTRIES + va[21:12];
    case (opc)
      OP_UNMAP: begin
        page_words[pos] = 32'd0;
        r.ok = 1'b1;
      end
      OP_QUERY: r.ok = page_words[pos][0];
      OP_TRANSLATE: begin
        if (page_words[pos][0]) begin
          r.xlat = (page_words[pos] & FRAME_MASK) | {20'd0, va[11:0]};
          r.ok = 1'b1;
        end
      end
      OP_GET_FLAGS: begin
        r.flags = page_words[pos][11:0];
        r.ok = 1'b1;
      end
      default: begin
        if (page_words[pos][0]) begin
          if (fl[2]) dir_user[dix] = 1'b1;
          page_words[pos] = (page_words[pos] & FRAME_MASK) | 32'(fl) | 32'(FLAG_PRESENT);
          r.ok = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (rst) begin
      reset_tables();
      result_q.delete();
    end else begin
      if (in_valid && in_ready)
        result_q.push_back(walk_tables(operation, virt_addr, phys_addr,
                                       page_flags));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (success !== want.ok) begin
            $error("success: expected %0h, got %0h", want.ok, success);
            errors++;
          end
          if (translated_address !== want.xlat) begin
            $error("translated_address: expected %08h, got %08h", want.xlat,
                   translated_address);
            errors++;
          end
          if (entry_flags !== want.flags) begin
            $error("entry_flags: expected %03h, got %03h", want.flags, entry_flags);
            errors++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ----- tb/two_level_page_table_manager_unit_tb.sv -----
module two_level_page_table_manager_unit_tb;
  import tlptm_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] page_flags;
  logic        out_valid;
  logic        out_ready;
  logic        success;
  logic [31:0] translated_address;
  logic [11:0] entry_flags;
  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  int          cycles;

  two_level_page_table_manager_unit u_top (.*);

  two_level_page_table_manager_unit_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1000000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver side; a long hold-off is counted here while the sender keeps going
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(logic [2:0] opc, logic [31:0] va, logic [31:0] pa,
                           logic [11:0] fl);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= opc;
    virt_addr  <= va;
    phys_addr  <= pa;
    page_flags <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly in-range directory entries on a few pages so maps get read back
  task automatic random_beat();
    logic [2:0]  opc;
    logic [31:0] va;
    logic [31:0] pa;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25)      opc = OP_MAP;
    else if (pick < 35) opc = OP_UNMAP;
    else if (pick < 50) opc = OP_QUERY;
    else if (pick < 72) opc = OP_TRANSLATE;
    else if (pick < 84) opc = OP_GET_FLAGS;
    else if (pick < 97) opc = OP_SET_FLAGS;
    else                opc = 3'($urandom_range(6, 7));
    va = $urandom();
    if ($urandom_range(99) < 90) begin
      va[31:22] = 10'($urandom_range(DIR_LIMIT - 1));
      if ($urandom_range(99) < 75) va[21:12] = 10'($urandom_range(7));
      if (opc != OP_TRANSLATE && opc != OP_GET_FLAGS && $urandom_range(99) < 92)
        va[11:0] = '0;
    end
    pa = $urandom();
    if ($urandom_range(99) < 90) pa[11:0] = '0;
    send_beat(opc, va, pa, 12'($urandom()));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_MAP;
    virt_addr = '0;
    phys_addr = '0;
    page_flags = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 80;
    send_beat(OP_TRANSLATE,  32'h00ABC123, '0, '0);
    send_beat(OP_TRANSLATE,  32'h00FFFFFF, '0, '0);
    send_beat(OP_GET_FLAGS,  32'h00401FFF, '0, '0);
    send_beat(OP_MAP,        32'h01400000, 32'hFFFFF000, 12'hFFF);
    send_beat(OP_TRANSLATE,  32'h01400ABC, '0, '0);
    send_beat(OP_GET_FLAGS,  32'h01401000, '0, '0);
    send_beat(OP_QUERY,      32'h01401000, '0, '0);
    send_beat(OP_SET_FLAGS,  32'h01401000, '0, 12'h004);
    send_beat(OP_SET_FLAGS,  32'h01400000, '0, 12'h000);
    send_beat(OP_QUERY,      32'h01400000, '0, '0);
    send_beat(OP_UNMAP,      32'h01400000, '0, '0);
    send_beat(OP_UNMAP,      32'h01400000, '0, '0);
    send_beat(OP_TRANSLATE,  32'h01400000, '0, '0);
    send_beat(OP_MAP,        32'h00001000, 32'h12345000, 12'h006);
    send_beat(OP_TRANSLATE,  32'h00001FFF, '0, '0);
    send_beat(OP_MAP,        32'h02000001, 32'h00000000, 12'h001);
    send_beat(OP_MAP,        32'h02000000, 32'h00000800, 12'h001);
    send_beat(OP_UNMAP,      32'h00000010, '0, '0);
    send_beat(OP_QUERY,      32'h03C00000, '0, '0);
    send_beat(OP_GET_FLAGS,  32'h03C00000, '0, '0);
    send_beat(OP_MAP,        32'h04000000, 32'h00001000, 12'h003);
    send_beat(OP_TRANSLATE,  32'hFFFFFFFF, '0, '0);
    send_beat(3'd6,          32'h00000000, '0, 12'hFFF);
    send_beat(3'd7,          32'hFFFFF000, 32'hFFFFFFFF, 12'hFFF);

    repeat (460) random_beat();
    // drain fully before switching
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    send_idle_pct = 80;
    recv_idle_pct = 26;
    repeat (460) random_beat();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (460) random_beat();
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tlptm_pkg.sv
sv/two_level_page_table_manager_unit.sv
tb/two_level_page_table_manager_unit_checker.sv
tb/two_level_page_table_manager_unit_tb.sv
